// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the RGB to HSL converter.
// Depends on nothing; expects the house clock and reset names in the user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequence in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/rgbhsl_pkg.sv =====
// Shared widths, constants and types of the RGB to HSL converter.
// Depends on nothing; used by the channel interfaces, the divider and the top level.
package rgbhsl_pkg;

   localparam int PIX_W       = 8;
   localparam int HSL_W       = 16;
   localparam int FRAC_W      = 15;

   localparam int DIV_NUM_W   = 24;
   localparam int DIV_DEN_W   = 9;
   localparam int DIV_QUO_W   = 16;
   localparam int DIV_LAT     = DIV_QUO_W + 2;

   localparam logic [DIV_DEN_W-1:0] LIGHT_DEN = 9'd510;
   localparam logic [DIV_DEN_W-1:0] SAT_SPLIT = 9'd255;
   localparam logic [DIV_NUM_W-1:0] SECTOR_Q  = 24'd7680;
   localparam logic [HSL_W-1:0]     HUE_FULL  = 16'd46080;
   localparam logic [HSL_W-1:0]     HSL_ONE   = 16'd32768;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

endpackage

// ===== design/rgbhsl_if.sv =====
// Valid/ready channel interfaces: RGB pixel requests and HSL responses.
// Depends on rgbhsl_pkg for the field widths.
interface rgbhsl_req_if import rgbhsl_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rgbhsl_rsp_if import rgbhsl_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [HSL_W-1:0] hue;
   logic [HSL_W-1:0] saturation;
   logic [HSL_W-1:0] lightness;

   modport source (output valid, hue, saturation, lightness, input ready);
   modport sink   (input valid, hue, saturation, lightness, output ready);
endinterface

// ===== design/rgbhsl_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, round to nearest.
// Depends on rgbhsl_pkg for default widths. Caller guarantees quotient < 2**QUO_W.
module rgbhsl_divider import rgbhsl_pkg::*; #(
   parameter int NUM_W = DIV_NUM_W,
   parameter int DEN_W = DIV_DEN_W,
   parameter int QUO_W = DIV_QUO_W
) (
   input  logic             clock,
   input  logic             advance,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quotient
);

   localparam int REM_W = DEN_W + 1;

   logic [REM_W-1:0] rem_ff  [QUO_W+1];
   logic [REM_W-1:0] rem_in  [QUO_W+1];
   logic [QUO_W-1:0] low_ff  [QUO_W];
   logic [QUO_W-1:0] low_in  [QUO_W];
   logic [DEN_W-1:0] den_ff  [QUO_W+1];
   logic [QUO_W-1:0] quo_ff  [QUO_W+1];
   logic [QUO_W-1:0] quo_in  [QUO_W+1];
   logic [QUO_W-1:0] quotient_ff;
   logic [QUO_W-1:0] quotient_in;
   logic             round_up;

   // Load: the high numerator bits are already below the divisor.
   always_comb begin
      rem_in[0] = REM_W'(num >> QUO_W);
      low_in[0] = num[QUO_W-1:0];
      quo_in[0] = '0;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= rem_in[0];
         low_ff[0] <= low_in[0];
         den_ff[0] <= den;
         quo_ff[0] <= quo_in[0];
      end
   end

   for (genvar k = 1; k <= QUO_W; k++) begin : g_step
      logic [REM_W-1:0] trial;
      logic             fits;

      always_comb begin
         trial     = {rem_ff[k-1][REM_W-2:0], low_ff[k-1][QUO_W-1]};
         fits      = trial >= {1'b0, den_ff[k-1]};
         rem_in[k] = fits ? (trial - {1'b0, den_ff[k-1]}) : trial;
         quo_in[k] = {quo_ff[k-1][QUO_W-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_ff[k-1];
            quo_ff[k] <= quo_in[k];
         end
      end

      if (k < QUO_W) begin : g_low
         always_comb low_in[k] = {low_ff[k-1][QUO_W-2:0], 1'b0};

         always_ff @(posedge clock) begin
            if (advance) begin
               low_ff[k] <= low_in[k];
            end
         end
      end
   end

   // Round half up: bump when twice the remainder reaches the divisor.
   always_comb begin
      round_up    = {rem_ff[QUO_W], 1'b0} >= {2'b00, den_ff[QUO_W]};
      quotient_in = quo_ff[QUO_W] + QUO_W'(round_up);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quotient_ff <= quotient_in;
      end
   end

   assign quotient = quotient_ff;

endmodule

// ===== design/rgb_to_hsl_converter.sv =====
// RGB to HSL colour-space converter, fully pipelined.
// Depends on rgbhsl_pkg, rgbhsl_if, rgbhsl_divider and assert_macros.svh.
//
// Usage:
//  - req_ch carries one 8-bit RGB pixel per transaction; rsp_ch returns one
//    hue (Q9.7 degrees), saturation (Q1.15) and lightness (Q1.15) per pixel,
//    in the order the pixels were taken.
//  - Throughput: one transaction per clock while the receiver keeps taking
//    responses. A request passes through the two front stages (min/max
//    and sector, then sums and hue numerator), the 16-stage pipelined
//    dividers with their load stage, and the rounding stage before its
//    response is offered.
//  - Two dividers run side by side: saturation (delta over the
//    lightness-dependent denominator) and hue (sector numerator over delta).
//    A grey pixel feeds zero over one, giving zero. Lightness divides by a
//    constant, so take it from a reciprocal multiply and delay it to match.
//  - Reset clears the valid bits only; the pipeline then holds no
//    transactions. Stateless otherwise.
//  - When the receiver stalls with a response waiting, the whole pipeline
//    holds and req_ch.ready drops; nothing is lost or repeated.
module rgb_to_hsl_converter import rgbhsl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   rgbhsl_req_if.sink         req_ch,
   rgbhsl_rsp_if.source       rsp_ch
);

`include "assert_macros.svh"

   localparam int PIPE_DEPTH = 2 + DIV_LAT;
   localparam int UNIT_W     = 11;

   // Lightness: sum*32768/510 = sum*64 + sum*64/255; round by adding half
   // the divisor, then take the quotient by 255 from a reciprocal multiply.
   localparam int                    LSCALE_W    = PIX_W + 7;
   localparam int                    LPROD_W     = LSCALE_W + 16;
   localparam logic [LSCALE_W-1:0]   LIGHT_BIAS  = 15'd127;
   localparam logic [15:0]           LIGHT_RECIP = 16'd32897;
   localparam int                    LIGHT_SHIFT = 23;

   // Valid bits travelling with the data.
   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [PIPE_DEPTH-1:0] valid_in;
   logic                  advance;

   // Stage 1: extremes and sector.
   logic [PIX_W-1:0] red_ff, green_ff, blue_ff, max_ff, min_ff;
   logic [PIX_W-1:0] max_in, min_in;
   sector_type       sector_ff, sector_in;

   // Stage 2: delta, sum, saturation divisor, hue units.
   logic [PIX_W-1:0]  delta_ff, delta_in;
   logic [PIX_W:0]    sum_ff, sum_in;
   logic [PIX_W-1:0]  sat_den_ff, sat_den_in;
   logic [UNIT_W-1:0] units_ff, units_in;

   // Divider operands.
   logic                 grey;
   logic [DIV_NUM_W-1:0] sat_num, hue_num;
   logic [DIV_DEN_W-1:0] sat_den, hue_den;
   logic [HSL_W-1:0]     sat_q, hue_q;

   // Lightness and its delay line.
   logic [LSCALE_W-1:0]  light_scaled;
   logic [LSCALE_W-1:0]  light_biased;
   logic [LPROD_W-1:0]   light_prod;
   logic [HSL_W-1:0]     light_in;
   logic [HSL_W-1:0]     light_ff [DIV_LAT];

   // Advance whenever the output stage is empty or being taken.
   assign advance      = ~valid_ff[PIPE_DEPTH-1] | rsp_ch.ready;
   assign req_ch.ready = advance;
   assign valid_in     = {valid_ff[PIPE_DEPTH-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Red wins ties, then green.
   always_comb begin
      max_in    = req_ch.red;
      min_in    = req_ch.red;
      sector_in = SECTOR_RED;
      if (req_ch.green > max_in) max_in = req_ch.green;
      if (req_ch.blue > max_in)  max_in = req_ch.blue;
      if (req_ch.green < min_in) min_in = req_ch.green;
      if (req_ch.blue < min_in)  min_in = req_ch.blue;
      if (req_ch.red != max_in) begin
         sector_in = (req_ch.green == max_in) ? SECTOR_GREEN : SECTOR_BLUE;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         red_ff    <= req_ch.red;
         green_ff  <= req_ch.green;
         blue_ff   <= req_ch.blue;
         max_ff    <= max_in;
         min_ff    <= min_in;
         sector_ff <= sector_in;
      end
   end

   // Hue units are hue in sixths of a turn scaled by delta; always in range,
   // so wrapping intermediates in UNIT_W bits is harmless.
   always_comb begin
      delta_in   = max_ff - min_ff;
      sum_in     = {1'b0, max_ff} + {1'b0, min_ff};
      sat_den_in = (sum_in <= SAT_SPLIT) ? sum_in[PIX_W-1:0]
                                         : PIX_W'(LIGHT_DEN - sum_in);
      case (sector_ff)
         SECTOR_RED: begin
            if (blue_ff > green_ff) begin
               units_in = UNIT_W'(6) * UNIT_W'(delta_in)
                        - UNIT_W'(blue_ff) + UNIT_W'(green_ff);
            end else begin
               units_in = UNIT_W'(green_ff) - UNIT_W'(blue_ff);
            end
         end
         SECTOR_GREEN: begin
            units_in = {UNIT_W'(delta_in)} << 1;
            units_in = units_in + UNIT_W'(blue_ff) - UNIT_W'(red_ff);
         end
         SECTOR_BLUE: begin
            units_in = {UNIT_W'(delta_in)} << 2;
            units_in = units_in + UNIT_W'(red_ff) - UNIT_W'(green_ff);
         end
         default: begin
            units_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         delta_ff   <= delta_in;
         sum_ff     <= sum_in;
         sat_den_ff <= sat_den_in;
         units_ff   <= units_in;
      end
   end

   // Feed zero over one for a grey pixel so hue and saturation come out zero.
   always_comb begin
      grey      = (delta_ff == '0);
      sat_num   = grey ? '0 : (DIV_NUM_W'(delta_ff) << FRAC_W);
      sat_den   = grey ? DIV_DEN_W'(1) : DIV_DEN_W'(sat_den_ff);
      hue_num   = grey ? '0 : (DIV_NUM_W'(units_ff) * SECTOR_Q);
      hue_den   = grey ? DIV_DEN_W'(1) : DIV_DEN_W'(delta_ff);
   end

   // Lightness never lands on a tie; the reciprocal is exact below 2**15.
   always_comb begin
      light_scaled = {sum_ff, 6'b000000};
      light_biased = light_scaled + LIGHT_BIAS;
      light_prod   = LPROD_W'(light_biased) * LPROD_W'(LIGHT_RECIP);
      light_in     = HSL_W'(light_scaled) + HSL_W'(light_prod >> LIGHT_SHIFT);
   end

   // Hold lightness back by the divider latency so the fields line up.
   always_ff @(posedge clock) begin
      if (advance) begin
         light_ff[0] <= light_in;
         for (int i = 1; i < DIV_LAT; i++) begin
            light_ff[i] <= light_ff[i-1];
         end
      end
   end

   rgbhsl_divider #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (DIV_DEN_W),
      .QUO_W (DIV_QUO_W)
   ) u_sat_div (
      .clock    (clock),
      .advance  (advance),
      .num      (sat_num),
      .den      (sat_den),
      .quotient (sat_q)
   );

   rgbhsl_divider #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (DIV_DEN_W),
      .QUO_W (DIV_QUO_W)
   ) u_hue_div (
      .clock    (clock),
      .advance  (advance),
      .num      (hue_num),
      .den      (hue_den),
      .quotient (hue_q)
   );

   // Wrap a rounded full turn back to zero.
   assign rsp_ch.valid      = valid_ff[PIPE_DEPTH-1];
   assign rsp_ch.hue        = (hue_q >= HUE_FULL) ? (hue_q - HUE_FULL) : hue_q;
   assign rsp_ch.saturation = sat_q;
   assign rsp_ch.lightness  = light_ff[DIV_LAT-1];

   `ASSERT_IMPLIES(a_hue_range, rsp_ch.valid, rsp_ch.hue < HUE_FULL, "hue beyond a full turn")
   `ASSERT_IMPLIES(a_unit_range, rsp_ch.valid,
      (rsp_ch.saturation <= HSL_ONE) && (rsp_ch.lightness <= HSL_ONE),
      "saturation or lightness above one")
   `ASSERT_IMPLIES(a_grey_hue, rsp_ch.valid && (rsp_ch.saturation == '0),
      rsp_ch.hue == '0, "grey pixel with non-zero hue")
   `ASSERT_NEXT(a_stall_hold, !advance, $stable(valid_ff), "pipeline moved during a stall")

endmodule

// ===== tb/rgb_hsl_checker.sv =====
// Checker for the RGB to HSL converter: watches both channels, predicts each
// response from the pixel taken and compares it field by field.
// Depends on rgbhsl_pkg for widths, fixed-point constants and the sector enum.
`timescale 1ns / 100ps

module rgb_hsl_checker import rgbhsl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic [PIX_W-1:0] req_red,
   input  logic [PIX_W-1:0] req_green,
   input  logic [PIX_W-1:0] req_blue,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [HSL_W-1:0] rsp_hue,
   input  logic [HSL_W-1:0] rsp_saturation,
   input  logic [HSL_W-1:0] rsp_lightness,
   output int               outstanding,
   output int               results_checked,
   output int               fail_count
);

   localparam int MAX_PRINTED = 30;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic [HSL_W-1:0] hue;
      logic [HSL_W-1:0] saturation;
      logic [HSL_W-1:0] lightness;
   } pixel_hsl_type;

   pixel_hsl_type expected_hsl [$];
   int            errors  = 0;
   int            checked = 0;

   assign fail_count      = errors;
   assign results_checked = checked;

   task automatic report_error(input string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("checker: %s", msg);
   endtask

   task automatic check_field(input string name, input pixel_hsl_type want,
                              input logic [HSL_W-1:0] got, input logic [HSL_W-1:0] exp_val);
      if (got !== exp_val)
         report_error($sformatf("pixel (%0d,%0d,%0d): %s is %0d, want %0d",
                                want.red, want.green, want.blue, name, got, exp_val));
   endtask

   // Round to nearest with ties up; the divisor is never zero here.
   function automatic int unsigned round_quotient(input int unsigned num,
                                                  input int unsigned den);
      return (2 * num + den) / (2 * den);
   endfunction

   function automatic pixel_hsl_type convert_pixel(input logic [PIX_W-1:0] r,
                                                   input logic [PIX_W-1:0] g,
                                                   input logic [PIX_W-1:0] b);
      int unsigned   rv, gv, bv, hi, lo, delta, total, span, units, hue_q;
      sector_type    sector;
      pixel_hsl_type res;
      rv = r;
      gv = g;
      bv = b;
      hi = rv;
      lo = rv;
      if (gv > hi) hi = gv;
      if (bv > hi) hi = bv;
      if (gv < lo) lo = gv;
      if (bv < lo) lo = bv;
      delta = hi - lo;
      total = hi + lo;

      res       = '0;
      res.red   = r;
      res.green = g;
      res.blue  = b;
      res.lightness = HSL_W'(round_quotient(total * HSL_ONE, LIGHT_DEN));

      // Grey pixels keep hue and saturation at zero.
      if (delta != 0) begin
         span = (total <= SAT_SPLIT) ? total : LIGHT_DEN - total;
         res.saturation = HSL_W'(round_quotient(delta * HSL_ONE, span));

         // Red wins ties, then green.
         if (hi == rv)      sector = SECTOR_RED;
         else if (hi == gv) sector = SECTOR_GREEN;
         else               sector = SECTOR_BLUE;

         // Hue in sixths of a turn, scaled by delta.
         case (sector)
            SECTOR_RED:   units = (bv > gv) ? 6 * delta - (bv - gv) : gv - bv;
            SECTOR_GREEN: units = 2 * delta + bv - rv;
            default:      units = 4 * delta + rv - gv;
         endcase
         hue_q = round_quotient(units * SECTOR_Q, delta);
         if (hue_q >= HUE_FULL) hue_q -= HUE_FULL;
         res.hue = HSL_W'(hue_q);
      end
      return res;
   endfunction

   always @(posedge clock) begin : track
      pixel_hsl_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_hsl.size() == 0) begin
               report_error($sformatf("response with no pixel outstanding: %0d %0d %0d",
                                      rsp_hue, rsp_saturation, rsp_lightness));
            end else begin
               want = expected_hsl.pop_front();
               checked++;
               check_field("hue", want, rsp_hue, want.hue);
               check_field("saturation", want, rsp_saturation, want.saturation);
               check_field("lightness", want, rsp_lightness, want.lightness);
            end
         end
         if (req_valid && req_ready)
            expected_hsl.push_back(convert_pixel(req_red, req_green, req_blue));
      end
      outstanding <= expected_hsl.size();
   end

endmodule

// ===== tb/tb_rgb_to_hsl_converter.sv =====
// Top of the RGB to HSL converter testbench: clock, reset, pixel stimulus,
// response stalls, watchdog and verdict.
// Depends on rgbhsl_pkg, rgbhsl_if, rgb_to_hsl_converter and rgb_hsl_checker.
`timescale 1ns / 100ps

module tb_rgb_to_hsl_converter import rgbhsl_pkg::*; ();

   localparam int RANDOM_PIXELS = 1300;
   localparam int LONG_HOLD     = 200;   // receiver hold-off, well past pipeline depth
   localparam int HOLD_AT       = 300;   // random pixel that triggers the hold-off
   localparam int HOLD_BURST    = 160;   // back-to-back pixels from the hold-off on
   localparam int DRAIN_AT      = 800;   // random pixel preceded by a full drain
   localparam int TAIL_CYCLES   = DIV_LAT + 6;
   localparam int IDLE_LIMIT    = 2000;

   // Corner pixels as {red, green, blue}.
   localparam logic [3*PIX_W-1:0] CORNER_PIXELS [0:22] = '{
      24'h000000,   // black
      24'hFFFFFF,   // white
      24'hFF0000,   // primaries
      24'h00FF00,
      24'h0000FF,
      24'hFFFF00,   // secondaries; red/green tie goes to red
      24'h00FFFF,   // green/blue tie goes to green
      24'hFF00FF,   // red/blue tie with blue above green
      24'h808080,   // mid grey
      24'h010101,   // near-black grey
      24'hFF0001,   // red sector with blue above green, hue just below a full turn
      24'hFF0100,
      24'hFFFFFE,
      24'hC864C8,
      24'h80807F,   // sum of max and min exactly at the saturation split
      24'h817F7F,   // sum just above the split
      24'hFEFFFF,
      24'h010000,   // smallest non-zero delta, dark
      24'h000001,
      24'hAA5500,
      24'h7F0000,
      24'h55AAFF,
      24'hFEFEFF
   };

   typedef enum logic [1:0] {
      MIX_RANDOM,
      MIX_NEAR_GREY,
      MIX_TIE,
      MIX_EXTREME
   } pixel_mix_type;

   logic clock;
   logic reset;
   int   outstanding;
   int   results_checked;
   int   fail_count;
   int   pixels_sent   = 0;
   int   hold_requests = 0;

   rgbhsl_req_if req_ch ();
   rgbhsl_rsp_if rsp_ch ();

   rgb_to_hsl_converter DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   rgb_hsl_checker u_hsl_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_red         (req_ch.red),
      .req_green       (req_ch.green),
      .req_blue        (req_ch.blue),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_hue         (rsp_ch.hue),
      .rsp_saturation  (rsp_ch.saturation),
      .rsp_lightness   (rsp_ch.lightness),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .fail_count      (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one pixel and hold it until the transaction completes. Drop valid
   // only when a gap or a drain comes first, so valid sees one update per step.
   task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                             input logic [PIX_W-1:0] b, input bit no_gap,
                             input bit drain_first);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 10);
      if (gap > 0 || drain_first) req_ch.valid <= 1'b0;
      if (drain_first) begin
         // Wait for every outstanding response before offering more.
         do @(posedge clock); while (outstanding != 0);
      end
      repeat (gap) @(posedge clock);
      req_ch.valid <= 1'b1;
      req_ch.red   <= r;
      req_ch.green <= g;
      req_ch.blue  <= b;
      do @(posedge clock); while (!req_ch.ready);
      pixels_sent++;
   endtask

   // Pixel source: corner cases first, then a weighted random mix.
   initial begin : pixel_source
      int               n;
      int               sel;
      int               base;
      pixel_mix_type    mix;
      logic [PIX_W-1:0] r, g, b;
      bit               no_gap;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.red   <= '0;
      req_ch.green <= '0;
      req_ch.blue  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (CORNER_PIXELS[i])
         send_pixel(CORNER_PIXELS[i][23:16], CORNER_PIXELS[i][15:8],
                    CORNER_PIXELS[i][7:0], 1'b0, 1'b0);

      for (n = 0; n < RANDOM_PIXELS; n++) begin
         sel = $urandom_range(0, 9);
         if (sel < 4)      mix = MIX_RANDOM;
         else if (sel < 6) mix = MIX_NEAR_GREY;
         else if (sel < 8) mix = MIX_TIE;
         else              mix = MIX_EXTREME;

         r = PIX_W'($urandom_range(0, 255));
         g = PIX_W'($urandom_range(0, 255));
         b = PIX_W'($urandom_range(0, 255));
         case (mix)
            MIX_NEAR_GREY: begin
               // Keep delta tiny so hue rounding and the grey path get exercised.
               base = $urandom_range(0, 255);
               r = PIX_W'(base);
               base = base + $urandom_range(0, 6) - 3;
               g = PIX_W'((base < 0) ? 0 : (base > 255) ? 255 : base);
               base = int'(r) + $urandom_range(0, 6) - 3;
               b = PIX_W'((base < 0) ? 0 : (base > 255) ? 255 : base);
            end
            MIX_TIE: begin
               case ($urandom_range(0, 2))
                  0:       g = r;
                  1:       b = r;
                  default: b = g;
               endcase
            end
            MIX_EXTREME: begin
               if ($urandom_range(0, 1)) r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               if ($urandom_range(0, 1)) g = $urandom_range(0, 1) ? 8'hFE : 8'h01;
               if ($urandom_range(0, 1)) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default: ;
         endcase

         // Ask the receiver for a long hold-off, then keep offering back to back
         // so the pipeline fills and the input stalls.
         if (n == HOLD_AT) hold_requests <= hold_requests + 1;
         no_gap = (n >= HOLD_AT && n < HOLD_AT + HOLD_BURST) || ((n / 50) % 6 == 3);
         send_pixel(r, g, b, no_gap, n == DRAIN_AT);
      end
      req_ch.valid <= 1'b0;

      // Drain, then allow the pipeline latency for any stray response.
      do @(posedge clock); while (outstanding != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("summary: %0d pixels sent (%0d corner cases), %0d responses checked",
               pixels_sent, $size(CORNER_PIXELS), results_checked);
      $display("summary: grey, tie, extreme and near-grey pixels under random stalls, %s",
               "a long output hold-off and a full drain");
      if (fail_count == 0 && outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Response sink: random hold-offs per transaction, quiet stretches, and a
   // long hold-off counted here whenever the source asks for one.
   initial begin : response_sink
      int gap;
      int taken;
      int served;
      taken  = 0;
      served = 0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_requests != served) begin
            gap = LONG_HOLD;
            served++;
         end else if ((taken / 60) % 5 == 2) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 10);
         end
         if (gap > 0) rsp_ch.ready <= 1'b0;
         repeat (gap) @(posedge clock);
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         taken++;
      end
   end

   // Watchdog: end the run when no transaction moves on either channel for too long.
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle = 0;
         else
            idle++;
      end
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("tb: failure");
      $finish;
   end

endmodule
